/* hdl/efd_pkg.sv */
// Package for the escaped frame decoder: shared widths, register indexes,
// reset values, state and class enums and the job and bank-done structs.
// No dependencies.
package efd_pkg;

   // Fixed field widths
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 6;
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_CODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SUBST  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_END_SUBST    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_SUBST = 3'd5;

   // Reset values of the code registers
   localparam logic [BYTE_W-1:0] RST_START_CODE   = 8'd2;
   localparam logic [BYTE_W-1:0] RST_END_CODE     = 8'd3;
   localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE  = 8'd16;
   localparam logic [BYTE_W-1:0] RST_START_SUBST  = 8'd18;
   localparam logic [BYTE_W-1:0] RST_END_SUBST    = 8'd19;
   localparam logic [BYTE_W-1:0] RST_ESCAPE_SUBST = 8'd17;

   // Deframer state
   typedef enum logic [1:0] {
      F_WAIT = 2'd0,
      F_READ = 2'd1,
      F_ESC  = 2'd2
   } front_state_type;

   // Class of a received byte, in match priority order
   typedef enum logic [2:0] {
      CLS_START,
      CLS_ESC,
      CLS_END,
      CLS_START_SUB,
      CLS_ESC_SUB,
      CLS_END_SUB,
      CLS_DATA
   } byte_class_type;

   // Output sequencer state
   typedef enum logic {
      B_IDLE = 1'b0,
      B_RUN  = 1'b1
   } back_state_type;

   // One completed frame waiting for output
   typedef struct packed {
      logic             bank;
      logic [LEN_W-1:0] len;
   } job_type;

   // Back reports a bank as fully read
   typedef struct packed {
      logic done;
      logic bank;
   } done_type;

endpackage

/* hdl/efd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module efd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/efd_queue.sv */
// Two-entry job queue between the deframer front and the output back.
// Depends on efd_pkg.
module efd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  efd_pkg::job_type push_job,
   input  logic             pop,
   output logic             head_valid,
   output efd_pkg::job_type head_job
);

   efd_pkg::job_type ent_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_valid = (cnt_ff != 2'd0);
   assign head_job   = ent_ff[rd_ptr_ff];

endmodule

/* hdl/efd_front.sv */
// Deframer front: code registers, byte classification, frame store writes
// and bank bookkeeping; pushes one job per completed frame. Uses efd_pkg.
module efd_front #(
   parameter int MAX_FRAME = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [efd_pkg::BYTE_W-1:0]        req_byte_in,
   input  logic                              csr_valid,
   input  logic [efd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [efd_pkg::BYTE_W-1:0]        csr_data,
   input  efd_pkg::done_type                 back_done,
   output logic                              wr_en,
   output logic [$clog2(MAX_FRAME):0]        wr_addr,
   output logic [efd_pkg::BYTE_W-1:0]        wr_data,
   output logic                              job_push,
   output efd_pkg::job_type                  job
);

   localparam int CNT_W  = $clog2(MAX_FRAME + 1);
   localparam int ADDR_W = $clog2(MAX_FRAME);

   logic [efd_pkg::BYTE_W-1:0] start_code_ff, end_code_ff, escape_code_ff;
   logic [efd_pkg::BYTE_W-1:0] start_subst_ff, end_subst_ff, escape_subst_ff;

   efd_pkg::front_state_type state_ff, state_in, cur_state;
   efd_pkg::byte_class_type  cls;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     bank_ff, bank_in;
   logic [1:0]               busy_ff, busy_in;
   logic                     accept;
   logic                     store_en, count_clr, frame_done;
   logic [efd_pkg::BYTE_W-1:0] store_byte;

   // Hold the code registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff   <= efd_pkg::RST_START_CODE;
         end_code_ff     <= efd_pkg::RST_END_CODE;
         escape_code_ff  <= efd_pkg::RST_ESCAPE_CODE;
         start_subst_ff  <= efd_pkg::RST_START_SUBST;
         end_subst_ff    <= efd_pkg::RST_END_SUBST;
         escape_subst_ff <= efd_pkg::RST_ESCAPE_SUBST;
      end else if (csr_valid) begin
         case (csr_index)
            efd_pkg::CSR_START_CODE:   start_code_ff   <= csr_data;
            efd_pkg::CSR_END_CODE:     end_code_ff     <= csr_data;
            efd_pkg::CSR_ESCAPE_CODE:  escape_code_ff  <= csr_data;
            efd_pkg::CSR_START_SUBST:  start_subst_ff  <= csr_data;
            efd_pkg::CSR_END_SUBST:    end_subst_ff    <= csr_data;
            efd_pkg::CSR_ESCAPE_SUBST: escape_subst_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Accept only while the bank being filled is not waiting for output
   assign req_ready = !busy_ff[bank_ff];
   assign accept    = req_valid && req_ready;

   // A full count forces the frame to abort
   assign cur_state = (count_ff >= CNT_W'(MAX_FRAME)) ? efd_pkg::F_WAIT : state_ff;

   // Classify the byte, first match wins
   always_comb begin
      if (req_byte_in == start_code_ff) begin
         cls = efd_pkg::CLS_START;
      end else if (req_byte_in == escape_code_ff) begin
         cls = efd_pkg::CLS_ESC;
      end else if (req_byte_in == end_code_ff) begin
         cls = efd_pkg::CLS_END;
      end else if (req_byte_in == start_subst_ff) begin
         cls = efd_pkg::CLS_START_SUB;
      end else if (req_byte_in == escape_subst_ff) begin
         cls = efd_pkg::CLS_ESC_SUB;
      end else if (req_byte_in == end_subst_ff) begin
         cls = efd_pkg::CLS_END_SUB;
      end else begin
         cls = efd_pkg::CLS_DATA;
      end
   end

   // Next deframer state
   always_comb begin
      unique case (cls)
         efd_pkg::CLS_START: state_in = efd_pkg::F_READ;
         efd_pkg::CLS_ESC:
            state_in = (cur_state == efd_pkg::F_READ) ? efd_pkg::F_ESC : efd_pkg::F_WAIT;
         efd_pkg::CLS_END: state_in = efd_pkg::F_WAIT;
         efd_pkg::CLS_START_SUB, efd_pkg::CLS_ESC_SUB, efd_pkg::CLS_END_SUB:
            state_in = (cur_state == efd_pkg::F_ESC) ? efd_pkg::F_READ : efd_pkg::F_WAIT;
         efd_pkg::CLS_DATA:
            state_in = (cur_state == efd_pkg::F_READ) ? efd_pkg::F_READ : efd_pkg::F_WAIT;
         default: state_in = efd_pkg::F_WAIT;
      endcase
   end

   // Deframer actions: store, clear count, finish frame
   always_comb begin
      store_en   = 1'b0;
      store_byte = req_byte_in;
      count_clr  = 1'b0;
      frame_done = 1'b0;
      unique case (cls)
         efd_pkg::CLS_START: count_clr = 1'b1;
         efd_pkg::CLS_ESC: ;
         efd_pkg::CLS_END: frame_done = (cur_state == efd_pkg::F_READ);
         efd_pkg::CLS_START_SUB: begin
            store_en   = (cur_state == efd_pkg::F_ESC);
            store_byte = start_code_ff;
         end
         efd_pkg::CLS_ESC_SUB: begin
            store_en   = (cur_state == efd_pkg::F_ESC);
            store_byte = escape_code_ff;
         end
         efd_pkg::CLS_END_SUB: begin
            store_en   = (cur_state == efd_pkg::F_ESC);
            store_byte = end_code_ff;
         end
         efd_pkg::CLS_DATA: store_en = (cur_state == efd_pkg::F_READ);
         default: ;
      endcase
   end

   // Store port and job push
   assign wr_en    = accept && store_en;
   assign wr_addr  = {bank_ff, count_ff[ADDR_W-1:0]};
   assign wr_data  = store_byte;
   assign job_push = accept && frame_done;
   assign job.bank = bank_ff;
   assign job.len  = efd_pkg::LEN_W'(count_ff);

   // Advance count and bank; track banks that hold a frame for output
   always_comb begin
      count_in = count_ff;
      bank_in  = bank_ff;
      busy_in  = busy_ff;
      if (accept) begin
         if (count_clr) begin
            count_in = '0;
         end else if (store_en) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (frame_done) begin
            bank_in          = ~bank_ff;
            busy_in[bank_ff] = 1'b1;
         end
      end
      if (back_done.done) begin
         busy_in[back_done.bank] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= efd_pkg::F_WAIT;
         count_ff <= '0;
         bank_ff  <= 1'b0;
         busy_ff  <= 2'b00;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         count_ff <= count_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

/* hdl/efd_back.sv */
// Output back: takes frame jobs from the queue, reads the stored bytes
// and drives the registered result channel. Uses efd_pkg.
module efd_back #(
   parameter int MAX_FRAME = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  efd_pkg::job_type              job,
   output logic                          job_pop,
   output logic                          rd_en,
   output logic [$clog2(MAX_FRAME):0]    rd_addr,
   input  logic [efd_pkg::BYTE_W-1:0]    rd_data,
   output efd_pkg::done_type             back_done,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [efd_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic [efd_pkg::LEN_W-1:0]     rsp_byte_index,
   output logic [efd_pkg::LEN_W-1:0]     rsp_frame_length,
   output logic                          rsp_last,
   output logic                          rsp_empty_frame
);

   localparam int ADDR_W = $clog2(MAX_FRAME);

   efd_pkg::back_state_type   state_ff, state_in;
   logic                      bank_ff;
   logic [efd_pkg::LEN_W-1:0] len_ff;
   logic [efd_pkg::LEN_W-1:0] k_ff;
   logic                      pend_ff;
   logic                      out_free, cap_last, is_empty;
   logic                      load_empty, capture;

   logic                      rsp_valid_ff;
   logic [efd_pkg::BYTE_W-1:0] data_ff;
   logic [efd_pkg::LEN_W-1:0] index_ff, length_ff;
   logic                      last_ff, empty_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_empty = (len_ff == '0);
   assign cap_last = (k_ff == len_ff - efd_pkg::LEN_W'(1));

   // Next sequencer state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         efd_pkg::B_IDLE: if (job_valid) state_in = efd_pkg::B_RUN;
         efd_pkg::B_RUN: begin
            if (is_empty) begin
               if (out_free) state_in = efd_pkg::B_IDLE;
            end else if (pend_ff && cap_last) begin
               state_in = efd_pkg::B_IDLE;
            end
         end
         default: state_in = efd_pkg::B_IDLE;
      endcase
   end

   // Sequencer outputs: pop, read issue, capture, completion
   always_comb begin
      job_pop    = 1'b0;
      rd_en      = 1'b0;
      load_empty = 1'b0;
      capture    = 1'b0;
      unique case (state_ff)
         efd_pkg::B_IDLE: job_pop = job_valid;
         efd_pkg::B_RUN: begin
            load_empty = is_empty && out_free;
            rd_en      = !is_empty && !pend_ff && out_free;
            capture    = !is_empty && pend_ff;
         end
         default: ;
      endcase
   end

   assign rd_addr        = {bank_ff, k_ff[ADDR_W-1:0]};
   assign back_done.done = load_empty || (capture && cap_last);
   assign back_done.bank = bank_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= efd_pkg::B_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rd_en) begin
            pend_ff <= 1'b1;
         end else if (capture) begin
            pend_ff <= 1'b0;
         end
         if (load_empty || capture) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Job and result payload
   always_ff @(posedge clock) begin
      if (job_pop) begin
         bank_ff <= job.bank;
         len_ff  <= job.len;
         k_ff    <= '0;
      end else if (capture && !cap_last) begin
         k_ff <= k_ff + efd_pkg::LEN_W'(1);
      end
      if (load_empty) begin
         data_ff   <= '0;
         index_ff  <= '0;
         length_ff <= '0;
         last_ff   <= 1'b1;
         empty_ff  <= 1'b1;
      end else if (capture) begin
         data_ff   <= rd_data;
         index_ff  <= k_ff;
         length_ff <= len_ff;
         last_ff   <= cap_last;
         empty_ff  <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_byte_index   = index_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_last         = last_ff;
   assign rsp_empty_frame  = empty_ff;

endmodule

/* hdl/escaped_frame_decoder_core.sv */
// Byte-stuffed frame decoder. The front classifies each received byte
// against six code registers and writes payload bytes into a two-bank
// frame store (each bank MAX_FRAME bytes rounded up to a power of two, one
// bank filling while the other is read out). A completed frame is queued
// and the back emits its bytes one at a time, issuing each read only after
// the byte before has gone through the store's registered read and been
// loaded into the output register; an empty frame gives a
// single result. The front stalls only when the bank it would fill still
// holds a frame waiting for output. The store needs no clearing after
// reset; frames carry at most MAX_FRAME-1 bytes. Write code registers only
// while the block is idle. Depends on efd_pkg, efd_ram, efd_queue,
// efd_front and efd_back.
module escaped_frame_decoder_core #(
   parameter int MAX_FRAME = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [efd_pkg::BYTE_W-1:0]    req_byte_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [efd_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic [efd_pkg::LEN_W-1:0]     rsp_byte_index,
   output logic [efd_pkg::LEN_W-1:0]     rsp_frame_length,
   output logic                          rsp_last,
   output logic                          rsp_empty_frame,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [efd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [efd_pkg::BYTE_W-1:0]    csr_data
);

   // One address bit selects the bank, the rest index within it
   localparam int RAM_AW    = $clog2(MAX_FRAME) + 1;
   localparam int RAM_DEPTH = 2 ** RAM_AW;

   logic                       wr_en, rd_en;
   logic [RAM_AW-1:0]          wr_addr, rd_addr;
   logic [efd_pkg::BYTE_W-1:0] wr_data, rd_data;
   logic                       job_push, job_pop, job_valid;
   efd_pkg::job_type           push_job, head_job;
   efd_pkg::done_type          back_done;

   // Register writes always complete at once
   assign csr_ready = 1'b1;

   efd_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_in (req_byte_in),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .back_done   (back_done),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .job_push    (job_push),
      .job         (push_job)
   );

   efd_ram #(
      .WIDTH (efd_pkg::BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   efd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (job_pop),
      .head_valid (job_valid),
      .head_job   (head_job)
   );

   efd_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (job_valid),
      .job              (head_job),
      .job_pop          (job_pop),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .back_done        (back_done),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last),
      .rsp_empty_frame  (rsp_empty_frame)
   );

`ifndef ASSERT_OFF
   // An empty-frame result is always the last of its frame
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_frame |-> rsp_last)
      else $error("empty frame result not marked last");

   // A payload result lies inside its frame
   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_frame |-> rsp_byte_index < rsp_frame_length)
      else $error("byte index beyond frame length");

   // The last payload result sits at the end of its frame
   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && !rsp_empty_frame
      |-> rsp_byte_index == rsp_frame_length - efd_pkg::LEN_W'(1))
      else $error("last marker not on final byte");

   // A bank completion comes only with a result being loaded
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      back_done.done |=> rsp_valid)
      else $error("bank released without a result");
`endif

endmodule

/* verif/tb.sv */
// Testbench for escaped_frame_decoder_core: feeds byte-stuffed frames and
// noise, predicts every result word and checks them in order.
// Depends on efd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

   localparam int MAX_FRAME     = 64;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_LIMIT   = 3000;

   // Indexes past the last code register; writes there must be dropped
   localparam logic [efd_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [efd_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef logic [efd_pkg::BYTE_W-1:0] octet_type;

   typedef struct packed {
      logic [efd_pkg::BYTE_W-1:0] data_byte;
      logic [efd_pkg::LEN_W-1:0]  byte_index;
      logic [efd_pkg::LEN_W-1:0]  frame_length;
      logic                       last;
      logic                       empty_frame;
   } out_word_type;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   octet_type                     req_byte_in = '0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   logic [efd_pkg::BYTE_W-1:0]    rsp_data_byte;
   logic [efd_pkg::LEN_W-1:0]     rsp_byte_index;
   logic [efd_pkg::LEN_W-1:0]     rsp_frame_length;
   logic                          rsp_last;
   logic                          rsp_empty_frame;
   logic                          csr_valid   = 1'b0;
   logic                          csr_ready;
   logic [efd_pkg::CSR_IDX_W-1:0] csr_index   = '0;
   octet_type                     csr_data    = '0;

   // Deframer shadow: state, fill count, frame bytes and code registers
   efd_pkg::front_state_type fstate   = efd_pkg::F_WAIT;
   logic [6:0]               fill_cnt = '0;
   octet_type                frame_buf [64];
   octet_type                code_start = efd_pkg::RST_START_CODE;
   octet_type                code_end   = efd_pkg::RST_END_CODE;
   octet_type                code_esc   = efd_pkg::RST_ESCAPE_CODE;
   octet_type                sub_start  = efd_pkg::RST_START_SUBST;
   octet_type                sub_end    = efd_pkg::RST_END_SUBST;
   octet_type                sub_esc    = efd_pkg::RST_ESCAPE_SUBST;

   out_word_type expected_words [$];
   out_word_type want;

   int idle_pct        = 0;
   int stall_pct       = 0;
   int hold_requests   = 0;
   int holds_taken     = 0;
   int hold_left       = 0;
   int quiet_cycles    = 0;
   int mismatches      = 0;
   int words_checked   = 0;
   int frames_expected = 0;
   int items_sent      = 0;
   int settings_used   = 0;

   escaped_frame_decoder_core #(
      .MAX_FRAME(MAX_FRAME)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last),
      .rsp_empty_frame  (rsp_empty_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Deframer prediction
   // ---------------------------------------------------------------

   task automatic store_payload(input octet_type b);
      frame_buf[fill_cnt[5:0]] = b;
      fill_cnt = fill_cnt + 7'd1;
   endtask

   // Substitute code: only meaningful right after an escape
   task automatic unescape(input octet_type b);
      if (fstate == efd_pkg::F_ESC) begin
         store_payload(b);
         fstate = efd_pkg::F_READ;
      end else begin
         fstate = efd_pkg::F_WAIT;
      end
   endtask

   task automatic predict_byte(input octet_type b);
      efd_pkg::byte_class_type cls;
      int                      n;
      out_word_type            w;
      // A full count aborts before the byte is looked at
      if (fill_cnt >= MAX_FRAME) fstate = efd_pkg::F_WAIT;
      if (b == code_start)      cls = efd_pkg::CLS_START;
      else if (b == code_esc)   cls = efd_pkg::CLS_ESC;
      else if (b == code_end)   cls = efd_pkg::CLS_END;
      else if (b == sub_start)  cls = efd_pkg::CLS_START_SUB;
      else if (b == sub_esc)    cls = efd_pkg::CLS_ESC_SUB;
      else if (b == sub_end)    cls = efd_pkg::CLS_END_SUB;
      else                      cls = efd_pkg::CLS_DATA;
      case (cls)
         efd_pkg::CLS_START: begin
            fill_cnt = '0;
            fstate   = efd_pkg::F_READ;
         end
         efd_pkg::CLS_ESC:
            fstate = (fstate == efd_pkg::F_READ) ? efd_pkg::F_ESC : efd_pkg::F_WAIT;
         efd_pkg::CLS_END: begin
            // Emit the stored frame, or one empty word
            if (fstate == efd_pkg::F_READ) begin
               n = (fill_cnt > 63) ? 63 : int'(fill_cnt);
               frames_expected++;
               if (n == 0) begin
                  w.data_byte    = '0;
                  w.byte_index   = '0;
                  w.frame_length = '0;
                  w.last         = 1'b1;
                  w.empty_frame  = 1'b1;
                  expected_words.push_back(w);
               end else begin
                  for (int k = 0; k < n; k++) begin
                     w.data_byte    = frame_buf[k];
                     w.byte_index   = efd_pkg::LEN_W'(k);
                     w.frame_length = efd_pkg::LEN_W'(n);
                     w.last         = (k + 1 == n);
                     w.empty_frame  = 1'b0;
                     expected_words.push_back(w);
                  end
               end
            end
            fstate = efd_pkg::F_WAIT;
         end
         efd_pkg::CLS_START_SUB: unescape(code_start);
         efd_pkg::CLS_ESC_SUB:   unescape(code_esc);
         efd_pkg::CLS_END_SUB:   unescape(code_end);
         default: begin
            if (fstate == efd_pkg::F_READ) store_payload(b);
            else fstate = efd_pkg::F_WAIT;
         end
      endcase
   endtask

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------

   // Offer one byte after optional idle cycles; predict on acceptance
   task automatic send_byte(input octet_type b);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid   <= 1'b0;
         req_byte_in <= octet_type'($urandom);
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      predict_byte(b);
   endtask

   task automatic csr_write(input logic [efd_pkg::CSR_IDX_W-1:0] idx,
                            input octet_type val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         efd_pkg::CSR_START_CODE:   code_start = val;
         efd_pkg::CSR_END_CODE:     code_end   = val;
         efd_pkg::CSR_ESCAPE_CODE:  code_esc   = val;
         efd_pkg::CSR_START_SUBST:  sub_start  = val;
         efd_pkg::CSR_END_SUBST:    sub_end    = val;
         efd_pkg::CSR_ESCAPE_SUBST: sub_esc    = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every expected word, then let the front settle
   task automatic drain_outputs();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_codes(input octet_type s, input octet_type e,
                              input octet_type x, input octet_type ss,
                              input octet_type es, input octet_type xs);
      csr_write(efd_pkg::CSR_START_CODE, s);
      csr_write(efd_pkg::CSR_END_CODE, e);
      csr_write(efd_pkg::CSR_ESCAPE_CODE, x);
      csr_write(efd_pkg::CSR_START_SUBST, ss);
      csr_write(efd_pkg::CSR_END_SUBST, es);
      csr_write(efd_pkg::CSR_ESCAPE_SUBST, xs);
      settings_used++;
   endtask

   task automatic apply_random_codes();
      octet_type c [6];
      bit        clash;
      for (int i = 0; i < 6; i++) begin
         do begin
            c[i]  = octet_type'($urandom);
            clash = 1'b0;
            for (int j = 0; j < i; j++) if (c[j] == c[i]) clash = 1'b1;
         end while (clash);
      end
      apply_codes(c[0], c[1], c[2], c[3], c[4], c[5]);
   endtask

   task automatic set_idling(input int sender, input int receiver);
      idle_pct  = sender;
      stall_pct = receiver;
   endtask

   // Payload byte: often a framing code, never a bare substitute code
   function automatic octet_type pick_payload();
      octet_type b;
      do begin
         case ($urandom_range(9))
            0:       b = code_start;
            1:       b = code_end;
            2:       b = code_esc;
            default: b = octet_type'($urandom);
         endcase
      end while (b != code_start && b != code_end && b != code_esc &&
                 (b == sub_start || b == sub_end || b == sub_esc));
      return b;
   endfunction

   // Plain data byte that matches no code at all
   function automatic octet_type pick_data();
      octet_type b;
      do begin
         b = octet_type'($urandom);
      end while (b == code_start || b == code_end || b == code_esc ||
                 b == sub_start || b == sub_end || b == sub_esc);
      return b;
   endfunction

   // Stuff framing codes as escape plus substitute
   task automatic send_payload(input octet_type b);
      if (b == code_start) begin
         send_byte(code_esc);
         send_byte(sub_start);
      end else if (b == code_end) begin
         send_byte(code_esc);
         send_byte(sub_end);
      end else if (b == code_esc) begin
         send_byte(code_esc);
         send_byte(sub_esc);
      end else begin
         send_byte(b);
      end
   endtask

   task automatic send_frame(input int len, input bit close);
      send_byte(code_start);
      repeat (len) send_payload(pick_payload());
      if (close) send_byte(code_end);
   endtask

   // Frame of plain data bytes, one byte on the line per payload byte
   task automatic send_raw_frame(input int len, input bit close);
      send_byte(code_start);
      repeat (len) send_byte(pick_data());
      if (close) send_byte(code_end);
   endtask

   task automatic send_noise();
      case ($urandom_range(3))
         0: repeat ($urandom_range(1, 4)) send_byte(octet_type'($urandom));
         1: begin
            // broken escape inside a frame
            send_byte(code_start);
            repeat ($urandom_range(0, 3)) send_payload(pick_payload());
            send_byte(code_esc);
            send_byte(octet_type'($urandom));
            send_byte(code_end);
         end
         2: send_frame($urandom_range(0, 5), 1'b0);
         default: begin
            send_byte(code_end);
            send_byte(sub_end);
         end
      endcase
   endtask

   // Mostly well-formed frames, some noise, then drain
   task automatic random_traffic(input int n);
      int stop_at;
      int r;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 70)      send_frame($urandom_range(0, 6), 1'b1);
         else if (r < 85) send_frame($urandom_range(7, 16), 1'b1);
         else             send_noise();
      end
      drain_outputs();
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   task automatic test_directed_codes();
      set_idling(0, 0);
      // payload extremes and all three escaped codes
      send_byte(code_start);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(code_esc);
      send_byte(sub_start);
      send_byte(code_esc);
      send_byte(sub_end);
      send_byte(code_esc);
      send_byte(sub_esc);
      send_byte(code_end);
      // empty frame
      send_byte(code_start);
      send_byte(code_end);
      // end, substitute and data while waiting: ignored
      send_byte(code_end);
      send_byte(sub_start);
      send_byte(8'h41);
      // unknown code after escape aborts
      send_byte(code_start);
      send_byte(code_esc);
      send_byte(8'h55);
      send_byte(code_end);
      // start inside a frame restarts it
      send_byte(code_start);
      send_byte(8'h41);
      send_byte(code_start);
      send_byte(8'h42);
      send_byte(code_end);
      drain_outputs();
   endtask

   task automatic test_frame_limits();
      set_idling(38, 38);
      send_raw_frame(MAX_FRAME - 1, 1'b1);
      // full count: the end byte aborts instead of emitting
      send_raw_frame(MAX_FRAME, 1'b1);
      // count still full, then a fresh start gives an empty frame
      send_frame(0, 1'b1);
      send_frame(1, 1'b1);
      drain_outputs();
   endtask

   // Hold the output long enough for both banks to fill and stall input
   task automatic test_backpressure();
      set_idling(0, 0);
      hold_requests++;
      repeat (3) send_frame(10, 1'b1);
      drain_outputs();
   endtask

   task automatic test_code_settings();
      set_idling(0, 65);
      apply_codes(8'h00, 8'hFF, 8'hFE, 8'h01, 8'h7F, 8'h80);
      random_traffic(6);
      apply_codes(8'hFF, 8'h00, 8'h01, 8'hFE, 8'h80, 8'h7F);
      random_traffic(6);
      // overlapping codes: the earlier class in match order wins
      apply_codes(8'h02, 8'h03, 8'h10, 8'h12, 8'h12, 8'h10);
      random_traffic(6);
      // writes to unused indexes must leave the codes alone
      apply_codes(efd_pkg::RST_START_CODE, efd_pkg::RST_END_CODE,
                  efd_pkg::RST_ESCAPE_CODE, efd_pkg::RST_START_SUBST,
                  efd_pkg::RST_END_SUBST, efd_pkg::RST_ESCAPE_SUBST);
      csr_write(CSR_SPARE_LO, efd_pkg::RST_END_CODE);
      csr_write(CSR_SPARE_HI, 8'hFF);
      random_traffic(6);
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       set_idling(0, 0);
            1:       set_idling(65, 0);
            2:       set_idling(0, 65);
            default: set_idling(38, 38);
         endcase
         apply_random_codes();
         random_traffic(8);
      end
   endtask

   // ---------------------------------------------------------------
   // Receiver, checker and watchdog
   // ---------------------------------------------------------------

   always @(negedge clock) begin
      if (hold_requests != holds_taken) begin
         holds_taken = hold_requests;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic check_field(input string what, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (act_v !== exp_v) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
      end
   endtask

   // Compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word: expected none, actual data %0d index %0d len %0d",
                     $time, rsp_data_byte, rsp_byte_index, rsp_frame_length);
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("byte_index", 8'(want.byte_index), 8'(rsp_byte_index));
            check_field("frame_length", 8'(want.frame_length), 8'(rsp_frame_length));
            check_field("last", 8'(want.last), 8'(rsp_last));
            check_field("empty_frame", 8'(want.empty_frame), 8'(rsp_empty_frame));
         end
      end
   end

   // End the run if no word moves on any channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                  $time, quiet_cycles, expected_words.size());
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_codes();
      test_frame_limits();
      test_backpressure();
      test_code_settings();
      test_random_traffic();
      $display("Sent %0d bytes under %0d code settings, four idle/stall mixes and one long hold.",
               items_sent, settings_used);
      $display("Checked %0d result words from %0d frames, %0d mismatches.",
               words_checked, frames_expected, mismatches);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
